// ----- src/ris_pkg.sv -----
// types, widths and register indexes shared by the ray/sphere intersection block
package ris_pkg;

    localparam int A_W    = 64;
    localparam int HM_W   = 65;
    localparam int KM_W   = 66;
    localparam int DISC_W = 132;
    localparam int ROOT_W = 66;
    localparam int NUM_W  = 67;
    localparam int T_W    = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATERIAL_TAG = 3'd5;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ris_ray_t;

    typedef struct packed {
        logic               hit_flag;
        logic [T_W-1:0]     distance;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [15:0]        hit_material;
    } ris_hit_t;

    typedef struct packed {
        ris_ray_t        ray;
        logic            miss;
        logic            hneg;
        logic [HM_W-1:0] hm;
        logic [A_W-1:0]  a;
    } ris_sq_side_t;

    typedef struct packed {
        ris_ray_t ray;
        logic     miss;
        logic     near_ok;
        logic     near_ovf;
    } ris_tdiv_side_t;

    typedef struct packed {
        logic               hit;
        logic [T_W-1:0]     t;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic               ovf;
        logic               neg;
    } ris_ndiv_side_t;

endpackage

// ----- src/ris_front.sv -----
// front pipeline: offset, dot products, discriminant of the quadratic
module ris_front #(
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [SIDE_W-1:0]            side_in,
    input  ris_pkg::ris_ray_t            ray,
    input  logic signed [31:0]           center_x,
    input  logic signed [31:0]           center_y,
    input  logic signed [31:0]           center_z,
    input  logic [30:0]                  radius,
    output logic                         out_vld,
    output logic [SIDE_W-1:0]            side_out,
    output logic [ris_pkg::DISC_W-1:0]   disc,
    output logic                         miss,
    output logic                         hneg,
    output logic [ris_pkg::HM_W-1:0]     hm,
    output logic [ris_pkg::A_W-1:0]      a
);
    import ris_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic signed [31:0] o_ax [3];
    logic signed [31:0] d_ax [3];
    logic signed [31:0] c_ax [3];

    assign o_ax[0] = ray.origin_x;
    assign o_ax[1] = ray.origin_y;
    assign o_ax[2] = ray.origin_z;
    assign d_ax[0] = ray.dir_x;
    assign d_ax[1] = ray.dir_y;
    assign d_ax[2] = ray.dir_z;
    assign c_ax[0] = center_x;
    assign c_ax[1] = center_y;
    assign c_ax[2] = center_z;

    // stage 1: magnitudes
    logic signed [32:0] oc_c [3];
    logic [32:0]        mo_next [3];
    logic [31:0]        md_next [3];
    logic [2:0]         ng_next;
    logic [32:0]        mo_reg [3];
    logic [31:0]        md_reg [3];
    logic [2:0]         ng_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            oc_c[i]    = 33'(o_ax[i]) - 33'(c_ax[i]);
            mo_next[i] = oc_c[i][32] ? 33'(-oc_c[i]) : 33'(oc_c[i]);
            md_next[i] = d_ax[i][31] ? 32'(-d_ax[i]) : 32'(d_ax[i]);
            ng_next[i] = oc_c[i][32] ^ d_ax[i][31];
        end
    end

    // stage 2: products
    logic [63:0] dd_next [3];
    logic [64:0] od_next [3];
    logic [65:0] oo_next [3];
    logic [61:0] rr_next;
    logic [63:0] dd_reg [3];
    logic [64:0] od_reg [3];
    logic [65:0] oo_reg [3];
    logic [61:0] rr_reg;
    logic [2:0]  ng2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_next[i] = md_reg[i] * md_reg[i];
            od_next[i] = mo_reg[i] * md_reg[i];
            oo_next[i] = mo_reg[i] * mo_reg[i];
        end
        rr_next = radius * radius;
    end

    // stage 3: sums
    logic [A_W-1:0]  a3_next;
    logic [HM_W-1:0] hp_next;
    logic [HM_W-1:0] hn_next;
    logic [KM_W-1:0] ss_next;
    logic [A_W-1:0]  a3_reg;
    logic [HM_W-1:0] hp_reg;
    logic [HM_W-1:0] hn_reg;
    logic [KM_W-1:0] ss_reg;
    logic [61:0]     rr3_reg;

    always_comb
    begin
        a3_next = dd_reg[0] + dd_reg[1] + dd_reg[2];
        hp_next = '0;
        hn_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (ng2_reg[i])
            begin
                hn_next = hn_next + od_reg[i];
            end
            else
            begin
                hp_next = hp_next + od_reg[i];
            end
        end
        ss_next = oo_reg[0] + oo_reg[1] + oo_reg[2];
    end

    // stage 4: signed h and k as sign and magnitude
    logic            hneg4_next;
    logic [HM_W-1:0] hm4_next;
    logic            kneg4_next;
    logic [KM_W-1:0] km4_next;
    logic            zero4_next;
    logic            hneg4_reg;
    logic [HM_W-1:0] hm4_reg;
    logic            kneg4_reg;
    logic [KM_W-1:0] km4_reg;
    logic            zero4_reg;
    logic [A_W-1:0]  a4_reg;

    always_comb
    begin
        hneg4_next = hn_reg > hp_reg;
        hm4_next   = hneg4_next ? hn_reg - hp_reg : hp_reg - hn_reg;
        kneg4_next = ss_reg < KM_W'(rr3_reg);
        km4_next   = kneg4_next ? KM_W'(rr3_reg) - ss_reg : ss_reg - KM_W'(rr3_reg);
        zero4_next = (a3_reg == '0) || (radius == '0);
    end

    // stage 5: partial products of h*h and a*k
    logic [63:0] phh_next;
    logic [64:0] phl_next;
    logic [65:0] pll_next;
    logic [64:0] pak_next [4];
    logic [63:0] phh_reg;
    logic [64:0] phl_reg;
    logic [65:0] pll_reg;
    logic [64:0] pak_reg [4];
    logic            hneg5_reg;
    logic [HM_W-1:0] hm5_reg;
    logic            kneg5_reg;
    logic            zero5_reg;
    logic [A_W-1:0]  a5_reg;

    always_comb
    begin
        phh_next    = hm4_reg[64:33] * hm4_reg[64:33];
        phl_next    = hm4_reg[64:33] * hm4_reg[32:0];
        pll_next    = hm4_reg[32:0] * hm4_reg[32:0];
        pak_next[0] = a4_reg[31:0] * km4_reg[32:0];
        pak_next[1] = a4_reg[31:0] * km4_reg[65:33];
        pak_next[2] = a4_reg[63:32] * km4_reg[32:0];
        pak_next[3] = a4_reg[63:32] * km4_reg[65:33];
    end

    // stage 6: recombine
    logic [DISC_W-1:0] h2_next;
    logic [DISC_W-1:0] ak_next;
    logic [DISC_W-1:0] h2_reg;
    logic [DISC_W-1:0] ak_reg;
    logic              hneg6_reg;
    logic [HM_W-1:0]   hm6_reg;
    logic              kneg6_reg;
    logic              zero6_reg;
    logic [A_W-1:0]    a6_reg;

    always_comb
    begin
        h2_next = (DISC_W'(phh_reg) << 66) + (DISC_W'(phl_reg) << 34) + DISC_W'(pll_reg);
        ak_next = DISC_W'(pak_reg[0]) + (DISC_W'(pak_reg[1]) << 33)
                + (DISC_W'(pak_reg[2]) << 32) + (DISC_W'(pak_reg[3]) << 65);
    end

    // stage 7: discriminant
    logic [DISC_W-1:0] disc_next;
    logic              miss_next;
    logic [DISC_W-1:0] disc_reg;
    logic              miss_reg;
    logic              hneg7_reg;
    logic [HM_W-1:0]   hm7_reg;
    logic [A_W-1:0]    a7_reg;

    always_comb
    begin
        disc_next = kneg6_reg ? h2_reg + ak_reg : h2_reg - ak_reg;
        miss_next = zero6_reg || (!kneg6_reg && (h2_reg < ak_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            mo_reg    <= mo_next;
            md_reg    <= md_next;
            ng_reg    <= ng_next;
            dd_reg    <= dd_next;
            od_reg    <= od_next;
            oo_reg    <= oo_next;
            rr_reg    <= rr_next;
            ng2_reg   <= ng_reg;
            a3_reg    <= a3_next;
            hp_reg    <= hp_next;
            hn_reg    <= hn_next;
            ss_reg    <= ss_next;
            rr3_reg   <= rr_reg;
            hneg4_reg <= hneg4_next;
            hm4_reg   <= hm4_next;
            kneg4_reg <= kneg4_next;
            km4_reg   <= km4_next;
            zero4_reg <= zero4_next;
            a4_reg    <= a3_reg;
            phh_reg   <= phh_next;
            phl_reg   <= phl_next;
            pll_reg   <= pll_next;
            pak_reg   <= pak_next;
            hneg5_reg <= hneg4_reg;
            hm5_reg   <= hm4_reg;
            kneg5_reg <= kneg4_reg;
            zero5_reg <= zero4_reg;
            a5_reg    <= a4_reg;
            h2_reg    <= h2_next;
            ak_reg    <= ak_next;
            hneg6_reg <= hneg5_reg;
            hm6_reg   <= hm5_reg;
            kneg6_reg <= kneg5_reg;
            zero6_reg <= zero5_reg;
            a6_reg    <= a5_reg;
            disc_reg  <= disc_next;
            miss_reg  <= miss_next;
            hneg7_reg <= hneg6_reg;
            hm7_reg   <= hm6_reg;
            a7_reg    <= a6_reg;
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];
    assign disc     = disc_reg;
    assign miss     = miss_reg;
    assign hneg     = hneg7_reg;
    assign hm       = hm7_reg;
    assign a        = a7_reg;

endmodule

// ----- src/ris_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module ris_sqrt #(
    parameter int RAD_W  = 132,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [SIDE_W-1:0]    side_in,
    input  logic [RAD_W-1:0]     rad,
    output logic                 out_vld,
    output logic [SIDE_W-1:0]    side_out,
    output logic [RAD_W/2-1:0]   root
);
    localparam int STEPS = RAD_W / 2;

    logic [STEPS-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [RAD_W-1:0]  n_reg [STEPS];
    logic [RAD_W-1:0]  res_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] n_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] rb;
        logic [RAD_W-1:0] n_next;
        logic [RAD_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign n_in   = rad;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign n_in   = n_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            rb = res_in + BIT;
            if (n_in >= rb)
            begin
                n_next   = n_in - rb;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                res_reg[k] <= res_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < STEPS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld  = vld_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];
    assign root     = res_reg[STEPS-1][STEPS-1:0];

endmodule

// ----- src/ris_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module ris_div #(
    parameter int STEPS  = 31,
    parameter int DEN_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [SIDE_W-1:0]  side_in,
    input  logic [DEN_W-1:0]   rem_in,
    input  logic [STEPS-1:0]   low_in,
    input  logic [DEN_W-1:0]   den,
    output logic               out_vld,
    output logic [SIDE_W-1:0]  side_out,
    output logic [STEPS-1:0]   quo
);
    logic [STEPS-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [DEN_W-1:0]  rem_reg [STEPS];
    logic [STEPS-1:0]  low_reg [STEPS];
    logic [DEN_W-1:0]  den_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_p;
        logic [STEPS-1:0] low_p;
        logic [DEN_W-1:0] den_p;
        logic [DEN_W:0]   r;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign rem_p = rem_in;
            assign low_p = low_in;
            assign den_p = den;
        end
        else
        begin : g_rest
            assign rem_p = rem_reg[k-1];
            assign low_p = low_reg[k-1];
            assign den_p = den_reg[k-1];
        end

        always_comb
        begin
            r        = {rem_p, low_p[STEPS-1]};
            ge       = r >= {1'b0, den_p};
            diff     = r - {1'b0, den_p};
            rem_next = ge ? diff[DEN_W-1:0] : r[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_p[STEPS-2:0], ge};
                den_reg[k] <= den_p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < STEPS; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld  = vld_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];
    assign quo      = low_reg[STEPS-1];

endmodule

// ----- src/ray_sphere_intersection.sv -----
// top level: ray/sphere intersection pipeline with configuration registers
//
// channel   direction  handshake              word
// ray       in         ray_valid/ray_ready    ris_ray_t: origin and direction
// hit       out        hit_valid/hit_ready    ris_hit_t: distance, normal, point, tag
// config    in         wr_en                  wr_index selects, wr_data holds value
//
// one word per cycle enters while the pipeline advances; the path to hit_valid runs
// through the 7-stage front, the 66-stage square root, the 31- and 32-stage divider
// chains, five single stages and the output register.
// the whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage in place.
// reset clears valid bits and sets configuration to its defaults; no clearing pass.
module ray_sphere_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ray_valid,
    output logic                                ray_ready,
    input  ris_pkg::ris_ray_t                   ray,
    output logic                                hit_valid,
    input  logic                                hit_ready,
    output ris_pkg::ris_hit_t                   hit,
    input  logic                                wr_en,
    input  logic [ris_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [ris_pkg::CFG_DATA_W-1:0]      wr_data
);
    import ris_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [30:0]        radius_reg;
    logic [15:0]        min_distance_reg;
    logic [15:0]        material_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            radius_reg       <= 31'd65536;
            min_distance_reg <= 16'd66;
            material_tag_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CENTER_X:     center_x_reg     <= wr_data;
                REG_CENTER_Y:     center_y_reg     <= wr_data;
                REG_CENTER_Z:     center_z_reg     <= wr_data;
                REG_RADIUS:       radius_reg       <= wr_data[30:0];
                REG_MIN_DISTANCE: min_distance_reg <= wr_data[15:0];
                REG_MATERIAL_TAG: material_tag_reg <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    logic     adv;
    ris_hit_t hit_reg;
    ris_hit_t hit_next;
    logic     hit_vld_reg;

    assign adv       = !hit_vld_reg || hit_ready;
    assign ray_ready = adv;

    // discriminant
    logic              f_vld;
    ris_ray_t          f_ray;
    logic [DISC_W-1:0] f_disc;
    logic              f_miss;
    logic              f_hneg;
    logic [HM_W-1:0]   f_hm;
    logic [A_W-1:0]    f_a;

    ris_front #(
        .SIDE_W ($bits(ris_ray_t))
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (ray_valid),
        .side_in  (ray),
        .ray      (ray),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .radius   (radius_reg),
        .out_vld  (f_vld),
        .side_out (f_ray),
        .disc     (f_disc),
        .miss     (f_miss),
        .hneg     (f_hneg),
        .hm       (f_hm),
        .a        (f_a)
    );

    // square root
    ris_sq_side_t      sq_in;
    ris_sq_side_t      sq_out;
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;

    assign sq_in = '{ray: f_ray, miss: f_miss, hneg: f_hneg, hm: f_hm, a: f_a};

    ris_sqrt #(
        .RAD_W  (DISC_W),
        .SIDE_W ($bits(ris_sq_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (f_vld),
        .side_in  (sq_in),
        .rad      (f_disc),
        .out_vld  (sq_vld),
        .side_out (sq_out),
        .root     (sq_root)
    );

    // root selection and divider setup
    logic [NUM_W-1:0] near_num;
    logic [NUM_W-1:0] far_num;
    logic [127:0]     near_full;
    logic [127:0]     far_full;
    logic             near_ok_next;
    logic             far_ok_next;

    ris_tdiv_side_t r_side_next;
    ris_tdiv_side_t r_side_reg;
    logic           r_vld_reg;
    logic [A_W-1:0] r_a_reg;
    logic [A_W-1:0] near_rem_reg;
    logic [A_W-1:0] far_rem_reg;
    logic [T_W-1:0] near_low_reg;
    logic [T_W-1:0] far_low_reg;
    logic           far_ok_reg;
    logic           far_ovf_reg;
    logic           far_ovf_next;

    always_comb
    begin
        near_ok_next = sq_out.hneg && (ROOT_W'(sq_out.hm) > sq_root);
        near_num     = NUM_W'(sq_out.hm) - NUM_W'(sq_root);
        far_ok_next  = sq_out.hneg || (sq_root > ROOT_W'(sq_out.hm));
        far_num      = sq_out.hneg ? NUM_W'(sq_root) + NUM_W'(sq_out.hm)
                                   : NUM_W'(sq_root) - NUM_W'(sq_out.hm);
        near_full    = 128'(near_num) << FRAC_BITS;
        far_full     = 128'(far_num) << FRAC_BITS;
        far_ovf_next = far_full[127:31] >= 97'(sq_out.a);
        r_side_next  = '{ray: sq_out.ray, miss: sq_out.miss, near_ok: near_ok_next,
                         near_ovf: near_full[127:31] >= 97'(sq_out.a)};
    end

    // distance division
    logic           dn_vld;
    logic           df_vld;
    ris_tdiv_side_t dn_side;
    logic [1:0]     df_side;
    logic [T_W-1:0] qn;
    logic [T_W-1:0] qf;

    ris_div #(
        .STEPS  (T_W),
        .DEN_W  (A_W),
        .SIDE_W ($bits(ris_tdiv_side_t))
    ) u_div_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (r_vld_reg),
        .side_in  (r_side_reg),
        .rem_in   (near_rem_reg),
        .low_in   (near_low_reg),
        .den      (r_a_reg),
        .out_vld  (dn_vld),
        .side_out (dn_side),
        .quo      (qn)
    );

    ris_div #(
        .STEPS  (T_W),
        .DEN_W  (A_W),
        .SIDE_W (2)
    ) u_div_far (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (r_vld_reg),
        .side_in  ({far_ok_reg, far_ovf_reg}),
        .rem_in   (far_rem_reg),
        .low_in   (far_low_reg),
        .den      (r_a_reg),
        .out_vld  (df_vld),
        .side_out (df_side),
        .quo      (qf)
    );

    // pick the root
    logic           t_near;
    logic [T_W-1:0] tn_sat;
    logic [T_W-1:0] tf_sat;
    logic           near_hit;
    logic           far_hit;
    logic           s1_vld_reg;
    ris_ray_t       s1_ray_reg;
    logic           s1_hit_reg;
    logic [T_W-1:0] s1_t_reg;

    always_comb
    begin
        tn_sat   = dn_side.near_ovf ? {T_W{1'b1}} : qn;
        tf_sat   = df_side[0] ? {T_W{1'b1}} : qf;
        near_hit = dn_side.near_ok && (tn_sat > T_W'(min_distance_reg));
        far_hit  = df_side[1] && (tf_sat > T_W'(min_distance_reg));
        t_near   = near_hit;
    end

    // t times direction
    logic signed [31:0] s_d  [3];
    logic signed [31:0] s_o  [3];
    logic signed [31:0] s_c  [3];
    logic signed [63:0] p_next [3];
    logic signed [63:0] p_reg  [3];
    logic               s2_vld_reg;
    ris_ray_t           s2_ray_reg;
    logic               s2_hit_reg;
    logic [T_W-1:0]     s2_t_reg;

    assign s_d[0] = s1_ray_reg.dir_x;
    assign s_d[1] = s1_ray_reg.dir_y;
    assign s_d[2] = s1_ray_reg.dir_z;
    assign s_o[0] = s2_ray_reg.origin_x;
    assign s_o[1] = s2_ray_reg.origin_y;
    assign s_o[2] = s2_ray_reg.origin_z;
    assign s_c[0] = center_x_reg;
    assign s_c[1] = center_y_reg;
    assign s_c[2] = center_z_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = $signed({1'b0, s1_t_reg}) * s_d[i];
        end
    end

    // hit point and normal numerator
    logic signed [63:0] q_c    [3];
    logic signed [31:0] pt_next [3];
    logic signed [63:0] num_next [3];
    logic signed [31:0] pt_reg  [3];
    logic signed [63:0] num_reg [3];
    logic               s3_vld_reg;
    logic               s3_hit_reg;
    logic [T_W-1:0]     s3_t_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_c[i]      = p_reg[i] >>> FRAC_BITS;
            pt_next[i]  = sat32(64'(s_o[i]) + q_c[i]);
            num_next[i] = 64'(s_o[i]) - 64'(s_c[i]) + q_c[i];
        end
    end

    // normal division setup
    logic [63:0]    mag_c  [3];
    logic [95:0]    nfull_c [3];
    logic [30:0]    nrem_next [3];
    logic [31:0]    nlow_next [3];
    logic [2:0]     novf_next;
    logic [2:0]     nneg_next;
    logic [30:0]    nrem_reg [3];
    logic [31:0]    nlow_reg [3];
    logic [2:0]     novf_reg;
    logic [2:0]     nneg_reg;
    logic           s4_vld_reg;
    logic           s4_hit_reg;
    logic [T_W-1:0] s4_t_reg;
    logic signed [31:0] s4_pt_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nneg_next[i] = num_reg[i][63];
            mag_c[i]     = num_reg[i][63] ? 64'(-num_reg[i]) : 64'(num_reg[i]);
            nfull_c[i]   = 96'(mag_c[i]) << FRAC_BITS;
            novf_next[i] = nfull_c[i][95:32] >= 64'(radius_reg);
            nrem_next[i] = nfull_c[i][62:32];
            nlow_next[i] = nfull_c[i][31:0];
        end
    end

    ris_ndiv_side_t nx_in;
    ris_ndiv_side_t nx_out;
    logic [1:0]     ny_out;
    logic [1:0]     nz_out;
    logic [2:0]     nd_vld;
    logic [31:0]    nq [3];

    assign nx_in = '{hit: s4_hit_reg, t: s4_t_reg, pt_x: s4_pt_reg[0], pt_y: s4_pt_reg[1],
                     pt_z: s4_pt_reg[2], ovf: novf_reg[0], neg: nneg_reg[0]};

    ris_div #(
        .STEPS  (32),
        .DEN_W  (31),
        .SIDE_W ($bits(ris_ndiv_side_t))
    ) u_div_nx (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .side_in  (nx_in),
        .rem_in   (nrem_reg[0]),
        .low_in   (nlow_reg[0]),
        .den      (radius_reg),
        .out_vld  (nd_vld[0]),
        .side_out (nx_out),
        .quo      (nq[0])
    );

    ris_div #(
        .STEPS  (32),
        .DEN_W  (31),
        .SIDE_W (2)
    ) u_div_ny (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .side_in  ({novf_reg[1], nneg_reg[1]}),
        .rem_in   (nrem_reg[1]),
        .low_in   (nlow_reg[1]),
        .den      (radius_reg),
        .out_vld  (nd_vld[1]),
        .side_out (ny_out),
        .quo      (nq[1])
    );

    ris_div #(
        .STEPS  (32),
        .DEN_W  (31),
        .SIDE_W (2)
    ) u_div_nz (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s4_vld_reg),
        .side_in  ({novf_reg[2], nneg_reg[2]}),
        .rem_in   (nrem_reg[2]),
        .low_in   (nlow_reg[2]),
        .den      (radius_reg),
        .out_vld  (nd_vld[2]),
        .side_out (nz_out),
        .quo      (nq[2])
    );

    // output word
    logic               o_ovf [3];
    logic               o_neg [3];
    logic signed [31:0] nrm   [3];

    always_comb
    begin
        o_ovf[0] = nx_out.ovf;
        o_neg[0] = nx_out.neg;
        o_ovf[1] = ny_out[1];
        o_neg[1] = ny_out[0];
        o_ovf[2] = nz_out[1];
        o_neg[2] = nz_out[0];
        for (int i = 0; i < 3; i++)
        begin
            if (o_ovf[i] || nq[i][31])
            begin
                nrm[i] = o_neg[i] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                nrm[i] = o_neg[i] ? 32'(-nq[i]) : nq[i];
            end
        end
        hit_next = '0;
        if (nx_out.hit)
        begin
            hit_next.hit_flag     = 1'b1;
            hit_next.distance     = nx_out.t;
            hit_next.normal_x     = nrm[0];
            hit_next.normal_y     = nrm[1];
            hit_next.normal_z     = nrm[2];
            hit_next.point_x      = nx_out.pt_x;
            hit_next.point_y      = nx_out.pt_y;
            hit_next.point_z      = nx_out.pt_z;
            hit_next.hit_material = material_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg   <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            hit_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_vld_reg   <= sq_vld;
            s1_vld_reg  <= dn_vld & df_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            hit_vld_reg <= &nd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_side_reg   <= r_side_next;
            r_a_reg      <= sq_out.a;
            near_rem_reg <= near_full[94:31];
            near_low_reg <= near_full[30:0];
            far_rem_reg  <= far_full[94:31];
            far_low_reg  <= far_full[30:0];
            far_ok_reg   <= far_ok_next;
            far_ovf_reg  <= far_ovf_next;
            s1_ray_reg   <= dn_side.ray;
            s1_hit_reg   <= !dn_side.miss && (near_hit || far_hit);
            s1_t_reg     <= t_near ? tn_sat : tf_sat;
            p_reg        <= p_next;
            s2_ray_reg   <= s1_ray_reg;
            s2_hit_reg   <= s1_hit_reg;
            s2_t_reg     <= s1_t_reg;
            pt_reg       <= pt_next;
            num_reg      <= num_next;
            s3_hit_reg   <= s2_hit_reg;
            s3_t_reg     <= s2_t_reg;
            nrem_reg     <= nrem_next;
            nlow_reg     <= nlow_next;
            novf_reg     <= novf_next;
            nneg_reg     <= nneg_next;
            s4_hit_reg   <= s3_hit_reg;
            s4_t_reg     <= s3_t_reg;
            s4_pt_reg    <= pt_reg;
            hit_reg      <= hit_next;
        end
    end

    assign hit_valid = hit_vld_reg;
    assign hit       = hit_reg;

endmodule

// ----- dv/ray_sphere_checker.sv -----
// checker for the ray/sphere intersection block: hit prediction and comparison
module ray_sphere_checker
    import ris_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ray_valid,
    input  logic                  ray_ready,
    input  ris_ray_t              ray,
    input  logic                  hit_valid,
    input  logic                  hit_ready,
    input  ris_hit_t              hit,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    failures,
    output int                    pending
);

    typedef logic signed [199:0] wide_t;

    localparam int FRAC_BITS_TB = 16;

    logic signed [31:0] sph_cx;
    logic signed [31:0] sph_cy;
    logic signed [31:0] sph_cz;
    logic [30:0]        sph_radius;
    logic [15:0]        sph_min_dist;
    logic [15:0]        sph_tag;

    ris_hit_t expected_hits[$];

    assign pending = expected_hits.size();

    function automatic wide_t isqrt(wide_t n);
        wide_t res;
        wide_t trial;
        res = 0;
        for (int b = 72; b >= 0; b--)
        begin
            trial = res | (wide_t'(1) <<< b);
            if (trial * trial <= n)
                res = trial;
        end
        return res;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // distance for one root numerator; ok is set when beyond the minimum distance
    function automatic longint root_distance(wide_t num, wide_t a, output bit ok);
        wide_t  tq;
        longint t;
        tq = (num <<< FRAC_BITS_TB) / a;
        t = (tq > 200'sd2147483647) ? 64'sd2147483647 : longint'(tq);
        ok = t > longint'(sph_min_dist);
        return t;
    endfunction

    function automatic ris_hit_t predict_hit(ris_ray_t r);
        ris_hit_t res;
        longint   o[3];
        longint   d[3];
        longint   oc[3];
        longint   cen[3];
        longint   rad;
        longint   t;
        longint   q;
        longint   num;
        longint   mag;
        longint   nm;
        longint   nv;
        wide_t    a;
        wide_t    h;
        wide_t    k;
        wide_t    disc;
        wide_t    s;
        bit       ok;
        res = '0;
        ok = 0;
        t = 0;
        o[0] = r.origin_x;
        o[1] = r.origin_y;
        o[2] = r.origin_z;
        d[0] = r.dir_x;
        d[1] = r.dir_y;
        d[2] = r.dir_z;
        cen[0] = sph_cx;
        cen[1] = sph_cy;
        cen[2] = sph_cz;
        rad = longint'(sph_radius);
        a = 0;
        h = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            oc[i] = o[i] - cen[i];
            a += wide_t'(d[i]) * wide_t'(d[i]);
            h += wide_t'(oc[i]) * wide_t'(d[i]);
            k += wide_t'(oc[i]) * wide_t'(oc[i]);
        end
        k -= wide_t'(rad) * wide_t'(rad);
        if (a == 0 || rad == 0)
            return res;
        disc = h * h - a * k;
        if (disc < 0)
            return res;
        s = isqrt(disc);
        if (-h - s > 0)
            t = root_distance(-h - s, a, ok);
        if (!ok && (-h + s > 0))
            t = root_distance(-h + s, a, ok);
        if (!ok)
            return res;
        res.hit_flag = 1'b1;
        res.distance = t[30:0];
        res.hit_material = sph_tag;
        for (int i = 0; i < 3; i++)
        begin
            q = (t * d[i]) >>> FRAC_BITS_TB;
            num = oc[i] + q;
            mag = (num < 0) ? -num : num;
            nm = (mag << FRAC_BITS_TB) / rad;
            if (nm > 64'sd2147483648)
                nv = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
            else
                nv = (num < 0) ? -nm : nm;
            nv = sat32(nv);
            q = sat32(o[i] + q);
            case (i)
                0:
                begin
                    res.normal_x = nv[31:0];
                    res.point_x  = q[31:0];
                end
                1:
                begin
                    res.normal_y = nv[31:0];
                    res.point_y  = q[31:0];
                end
                default:
                begin
                    res.normal_z = nv[31:0];
                    res.point_z  = q[31:0];
                end
            endcase
        end
        return res;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v,
                     act_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_cx       <= '0;
            sph_cy       <= '0;
            sph_cz       <= '0;
            sph_radius   <= 31'd65536;
            sph_min_dist <= 16'd66;
            sph_tag      <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CENTER_X:     sph_cx       <= wr_data;
                REG_CENTER_Y:     sph_cy       <= wr_data;
                REG_CENTER_Z:     sph_cz       <= wr_data;
                REG_RADIUS:       sph_radius   <= wr_data[30:0];
                REG_MIN_DISTANCE: sph_min_dist <= wr_data[15:0];
                REG_MATERIAL_TAG: sph_tag      <= wr_data[15:0];
                default:          ;
            endcase
        end
    end

    initial
        failures = 0;

    always @(posedge clk)
    begin
        ris_hit_t want;
        if (rst_n && ray_valid && ray_ready)
            expected_hits.push_back(predict_hit(ray));
        if (rst_n && hit_valid && hit_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected hit word, expected none, got %h", $realtime, hit);
                failures++;
            end
            else
            begin
                want = expected_hits.pop_front();
                check_field("hit_flag", want.hit_flag, hit.hit_flag);
                check_field("distance", want.distance, hit.distance);
                check_field("normal_x", want.normal_x, hit.normal_x);
                check_field("normal_y", want.normal_y, hit.normal_y);
                check_field("normal_z", want.normal_z, hit.normal_z);
                check_field("point_x", want.point_x, hit.point_x);
                check_field("point_y", want.point_y, hit.point_y);
                check_field("point_z", want.point_z, hit.point_z);
                check_field("hit_material", want.hit_material, hit.hit_material);
            end
        end
    end

endmodule

// ----- dv/ray_sphere_intersection_test.sv -----
// testbench top for the ray/sphere intersection block: stimulus and verdict
module ray_sphere_intersection_test;
    import ris_pkg::*;

    localparam int RAYS_PER_PHASE = 180;
    localparam int NUM_PHASES     = 7;
    localparam int DRAIN_CYCLES   = 400;
    localparam int STALL_LIMIT    = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  ray_valid;
    logic                  ray_ready;
    ris_ray_t              ray;
    logic                  hit_valid;
    logic                  hit_ready;
    ris_hit_t              hit;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    failures;
    int                    pending;
    bit                    quiet;
    int                    stall_cycles;

    // aiming copy of the sphere
    longint aim_cx;
    longint aim_cy;
    longint aim_cz;
    longint aim_radius;

    ray_sphere_intersection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_ready (ray_ready),
        .ray       (ray),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .hit       (hit),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    ray_sphere_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_valid (ray_valid),
        .ray_ready (ray_ready),
        .ray       (ray),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .hit       (hit),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        hit_ready <= quiet || ($urandom_range(99) >= 10);

    always @(posedge clk)
    begin
        if ((ray_valid && ray_ready) || (hit_valid && hit_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ray_sphere_intersection verification failed");
            $finish;
        end
    end

    function automatic ris_ray_t make_ray(longint ox, longint oy, longint oz,
                                          longint dx, longint dy, longint dz);
        ris_ray_t r;
        r.origin_x = ox[31:0];
        r.origin_y = oy[31:0];
        r.origin_z = oz[31:0];
        r.dir_x    = dx[31:0];
        r.dir_y    = dy[31:0];
        r.dir_z    = dz[31:0];
        return r;
    endfunction

    function automatic longint rand_span(longint span);
        longint v;
        v = {$urandom, $urandom};
        if (span <= 0)
            return 0;
        v = (v < 0) ? -v : v;
        return (v % (2 * span + 1)) - span;
    endfunction

    // mostly rays aimed through the sphere, some pure noise
    function automatic ris_ray_t aimed_ray();
        longint d[3];
        longint tgt[3];
        longint m;
        if ($urandom_range(99) < 15)
            return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 3; i++)
            d[i] = rand_span(longint'($urandom_range(1, 4)) * 65536);
        tgt[0] = aim_cx + rand_span(aim_radius);
        tgt[1] = aim_cy + rand_span(aim_radius);
        tgt[2] = aim_cz + rand_span(aim_radius);
        m = $urandom_range(8);
        if ($urandom_range(3) == 0)
            m = -m;
        return make_ray(tgt[0] - m * d[0], tgt[1] - m * d[1], tgt[2] - m * d[2],
                        d[0], d[1], d[2]);
    endfunction

    task automatic send_ray(ris_ray_t r);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 10)
        begin
            ray_valid <= 1'b0;
            @(negedge clk);
        end
        ray_valid <= 1'b1;
        ray <= r;
        do
            @(posedge clk);
        while (!ray_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        ray_valid <= 1'b0;
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_CENTER_X: aim_cx = longint'(signed'(val));
            REG_CENTER_Y: aim_cy = longint'(signed'(val));
            REG_CENTER_Z: aim_cz = longint'(signed'(val));
            REG_RADIUS:   aim_radius = longint'(val[30:0]);
            default:      ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        ray_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] mind, logic [31:0] tag);
        wait_idle();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_MIN_DISTANCE, mind);
        write_reg(REG_MATERIAL_TAG, tag);
    endtask

    initial
    begin
        rst_n = 1'b0;
        ray_valid = 1'b0;
        ray = '0;
        hit_ready = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        quiet = 1'b0;
        stall_cycles = 0;
        aim_cx = 0;
        aim_cy = 0;
        aim_cz = 0;
        aim_radius = 65536;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // unit sphere at the origin after reset
        send_ray(make_ray(0, 0, -5 * 65536, 0, 0, 65536));
        send_ray(make_ray(0, 0, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, -5 * 65536, 0, 0, 0));
        send_ray(make_ray(0, 65536, -5 * 65536, 0, 0, 65536));
        send_ray(make_ray(0, 2 * 65536, -5 * 65536, 0, 0, 65536));
        send_ray(make_ray(0, 0, -5 * 65536, 0, 0, -65536));
        send_ray(make_ray(0, 0, 65535, 0, 0, 65536));
        send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_ray(make_ray(0, 0, -32'sh7fff_ffff, 0, 0, 1));
        send_ray(make_ray(0, 0, -65536 * 2, 0, 0, 32'h7fff_ffff));
        send_ray(make_ray(-65536 * 3, 0, 0, 32'h8000_0000, 0, 0));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                    set_sphere($urandom_range(65536 * 8), -$urandom_range(65536 * 8),
                               $urandom, $urandom_range(65536, 65536 * 6) | 32'h8000_0000,
                               0, $urandom_range(65535));
                1:
                    set_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h7fff_ffff, 65535, 65535);
                2:
                    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0);
                3:
                    set_sphere(0, 0, 0, 0, 1, 16'h5a5a);
                4:
                    set_sphere(-65536 * 3, 65536 * 2, 65536, 65536 * 3, 65535, 16'ha5a5);
                default:
                    set_sphere($urandom_range(65536 * 64) - 65536 * 32,
                               $urandom_range(65536 * 64) - 65536 * 32,
                               $urandom_range(65536 * 64) - 65536 * 32,
                               $urandom_range(1, 65536 * 16), $urandom_range(65535),
                               $urandom_range(65535));
            endcase
            if (ph == 2)
            begin
                write_reg(3'd6, $urandom);
                write_reg(3'd7, $urandom);
            end
            quiet = (ph == 4);
            for (int n = 0; n < RAYS_PER_PHASE; n++)
                send_ray(aimed_ray());
            quiet = 1'b0;
        end

        wait_idle();
        if (failures == 0 && pending == 0)
            $display("ray_sphere_intersection verification clean");
        else
            $display("ray_sphere_intersection verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ris_pkg.sv
src/ris_front.sv
src/ris_sqrt.sv
src/ris_div.sv
src/ray_sphere_intersection.sv
dv/ray_sphere_checker.sv
dv/ray_sphere_intersection_test.sv
